@@ rtl/core/b64fd_pkg.sv @@
// Shared types and constants of the base64 frame decoder with Fletcher-16 check.
package b64fd_pkg;

  // Frames of this many bytes or more are rejected as a length error.
  localparam int unsigned MaxFrame = 128;

  // Reset value of the data-frame id mask.
  localparam logic [7:0] MaskReset = 8'h20;

  // Default depth of the event queue between front and back.
  localparam int unsigned QueueDepth = 4;

  // Width of the output word data bus.
  localparam int unsigned OutDataW = 80;

  // End-of-frame status codes.
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_LEN  = 2'd1,
    STAT_HDR  = 2'd2,
    STAT_CSUM = 2'd3
  } status_e;

  // Output word kinds, carried on tuser.
  localparam logic KindByte   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // One event per input word that causes output: a payload byte, a status, or both.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] byte_value;
    logic [6:0] byte_offset;
    logic       has_status;
    status_e    status;
    logic [7:0] msg_id;
    logic [31:0] time_stamp;
    logic [3:0] float_count;
    logic [3:0] int_count;
    logic [7:0] text_length;
    logic       is_data_frame;
  } evt_t;

  // Output data layout, last member in the lowest bits.
  typedef struct packed {
    logic [5:0]  pad;
    logic        is_data_frame;
    logic [7:0]  text_length;
    logic [3:0]  int_count;
    logic [3:0]  float_count;
    logic [31:0] time_stamp;
    logic [7:0]  msg_id;
    status_e     status;
    logic [6:0]  byte_offset;
    logic [7:0]  byte_value;
  } out_word_t;

endpackage

@@ rtl/core/b64fd_front.sv @@
// Front end: base64 decode, byte assembly, frame parsing and Fletcher-16 update.
module b64fd_front import b64fd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_data_i,
  input  logic       s_last_i,
  input  logic       full_i,
  output logic       push_o,
  output evt_t       evt_o
);

  // Returns {valid, six data bits} for one ASCII character.
  function automatic logic [6:0] decode_char(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  // Declared content length in bytes.
  function automatic logic [8:0] content_len(input logic [7:0] id, input logic [7:0] len,
                                             input logic [7:0] mask);
    logic [4:0] items;
    items = {1'b0, len[3:0]} + {1'b0, len[7:4]};
    if ((id & mask) != 8'd0) begin
      return {2'b00, items, 2'b00};
    end
    return {1'b0, len};
  endfunction

  logic [7:0]  mask_q, mask_d;
  logic [11:0] buf_q, buf_d;
  logic [3:0]  held_q, held_d;
  logic [7:0]  seen_q, seen_d;
  logic [7:0]  fl_q, fl_d;
  logic [7:0]  fh_q, fh_d;
  logic [7:0]  id_q, id_d;
  logic [31:0] time_q, time_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] sent_q, sent_d;
  logic        ovf_q, ovf_d;

  logic        accept;
  logic [6:0]  dec;
  logic [3:0]  held_add;
  logic [3:0]  held_rem;
  logic [11:0] buf_shift;
  logic        got_byte;
  logic [7:0]  byte_w;
  logic [8:0]  cont;
  logic [8:0]  lim;
  logic [8:0]  idx9;
  logic [8:0]  fl_sum, fh_sum;
  logic [7:0]  fl_mod, fh_mod;
  logic        take;
  logic        has_byte;
  logic [6:0]  byte_off;
  logic [8:0]  total;
  logic [8:0]  cont_d;
  logic [9:0]  need;
  logic        is_data_d;
  status_e     status;

  assign s_ready_o = !full_i;
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    mask_d = cfg_we_i ? cfg_wdata_i : mask_q;
  end

  always_comb begin
    buf_d   = buf_q;
    held_d  = held_q;
    seen_d  = seen_q;
    fl_d    = fl_q;
    fh_d    = fh_q;
    id_d    = id_q;
    time_d  = time_q;
    len_d   = len_q;
    sent_d  = sent_q;
    ovf_d   = ovf_q;
    has_byte = 1'b0;
    byte_off = '0;

    dec       = decode_char(s_data_i);
    held_add  = held_q + 4'd6;
    buf_shift = {buf_q[5:0], dec[5:0]};
    got_byte  = dec[6] && (held_add >= 4'd8);
    held_rem  = held_add - 4'd8;
    byte_w    = 8'(buf_shift >> held_rem);

    cont = content_len(id_q, len_q, mask_q);
    lim  = 9'd6 + cont;
    idx9 = {1'b0, seen_q};

    // Mod-255 sums: each sum is below 510, so one subtract corrects.
    fl_sum = {1'b0, fl_q} + {1'b0, byte_w};
    fl_mod = (fl_sum >= 9'd255) ? 8'(fl_sum - 9'd255) : fl_sum[7:0];
    fh_sum = {1'b0, fh_q} + {1'b0, fl_mod};
    fh_mod = (fh_sum >= 9'd255) ? 8'(fh_sum - 9'd255) : fh_sum[7:0];

    take = accept && got_byte && (seen_q != 8'hFF);

    if (accept && dec[6]) begin
      if (got_byte) begin
        held_d = held_rem;
        buf_d  = buf_shift & ((12'd1 << held_rem) - 12'd1);
        if (seen_q == 8'hFF) begin
          ovf_d = 1'b1;
        end
      end else begin
        held_d = held_add;
        buf_d  = buf_shift;
      end
    end

    if (take) begin
      if (idx9 < lim) begin
        fl_d = fl_mod;
        fh_d = fh_mod;
      end
      if (seen_q == 8'd0) begin
        id_d = byte_w;
      end else if (seen_q <= 8'd4) begin
        // Time stamp lanes are still zero, so writing a lane equals OR-ing it in.
        time_d[{2'(seen_q[1:0] - 2'd1), 3'b000} +: 8] = byte_w;
      end else if (seen_q == 8'd5) begin
        len_d = byte_w;
      end else if (idx9 < lim) begin
        has_byte = 1'b1;
        byte_off = 7'(seen_q - 8'd6);
      end else if (idx9 == lim) begin
        sent_d[7:0] = byte_w;
      end else if (idx9 == lim + 9'd1) begin
        sent_d[15:8] = byte_w;
      end
      seen_d = seen_q + 8'd1;
    end

    // Status is judged on the state after this word's byte.
    total     = ovf_d ? 9'd256 : {1'b0, seen_d};
    is_data_d = (id_d & mask_q) != 8'd0;
    cont_d    = content_len(id_d, len_d, mask_q);
    need      = 10'd8 + {1'b0, cont_d};
    if (total < 9'd7 || total >= 9'(MaxFrame) || {1'b0, total} < need) begin
      status = STAT_LEN;
    end else if ((id_d & 8'hC0) != 8'hC0) begin
      status = STAT_HDR;
    end else if ({fh_d, fl_d} != sent_d) begin
      status = STAT_CSUM;
    end else begin
      status = STAT_OK;
    end

    evt_o.has_byte      = has_byte;
    evt_o.byte_value    = byte_w;
    evt_o.byte_offset   = byte_off;
    evt_o.has_status    = s_last_i;
    evt_o.status        = status;
    evt_o.msg_id        = id_d;
    evt_o.time_stamp    = time_d;
    evt_o.float_count   = is_data_d ? len_d[3:0] : 4'd0;
    evt_o.int_count     = is_data_d ? len_d[7:4] : 4'd0;
    evt_o.text_length   = is_data_d ? 8'd0 : len_d;
    evt_o.is_data_frame = is_data_d;

    // The last character of a message closes the frame.
    if (accept && s_last_i) begin
      buf_d  = '0;
      held_d = '0;
      seen_d = '0;
      fl_d   = '0;
      fh_d   = '0;
      id_d   = '0;
      time_d = '0;
      len_d  = '0;
      sent_d = '0;
      ovf_d  = 1'b0;
    end
  end

  assign push_o = accept && (has_byte || s_last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MaskReset;
      buf_q  <= '0;
      held_q <= '0;
      seen_q <= '0;
      fl_q   <= '0;
      fh_q   <= '0;
      id_q   <= '0;
      time_q <= '0;
      len_q  <= '0;
      sent_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      mask_q <= mask_d;
      buf_q  <= buf_d;
      held_q <= held_d;
      seen_q <= seen_d;
      fl_q   <= fl_d;
      fh_q   <= fh_d;
      id_q   <= id_d;
      time_q <= time_d;
      len_q  <= len_d;
      sent_q <= sent_d;
      ovf_q  <= ovf_d;
    end
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_last_i |=> seen_q == 8'd0 && held_q == 4'd0 && !ovf_q)
    else $error("frame state not cleared after last character");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> seen_q == 8'hFF)
    else $error("overflow flag set before byte counter saturated");

endmodule

@@ rtl/core/b64fd_queue.sv @@
// Small register queue that carries events from the front end to the back end.
module b64fd_queue import b64fd_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  evt_t evt_i,
  output logic full_o,
  output logic evt_valid_o,
  output evt_t evt_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  evt_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o      = count_q == CntW'(DEPTH);
  assign evt_valid_o = count_q != '0;
  assign evt_o       = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && evt_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= evt_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("event pushed into a full queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count out of range");

endmodule

@@ rtl/core/b64fd_back.sv @@
// Back end: expands queued events into output words behind an output register.
module b64fd_back import b64fd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                evt_valid_i,
  input  evt_t                evt_i,
  output logic                pop_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [OutDataW-1:0] m_data_o,
  output logic                m_last_o,
  output logic                m_user_o
);

  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic                m_last_q, m_last_d;
  logic                m_user_q, m_user_d;
  logic                phase_q, phase_d;
  logic                load;
  logic                split;
  logic                emit_byte;
  out_word_t           word;

  assign load      = !m_valid_q || m_ready_i;
  assign split     = evt_i.has_byte && evt_i.has_status;
  assign emit_byte = evt_i.has_byte && !phase_q;
  assign pop_o     = load && evt_valid_i && !(split && !phase_q);

  always_comb begin
    word = '0;
    if (emit_byte) begin
      word.byte_value  = evt_i.byte_value;
      word.byte_offset = evt_i.byte_offset;
    end else begin
      word.status        = evt_i.status;
      word.msg_id        = evt_i.msg_id;
      word.time_stamp    = evt_i.time_stamp;
      word.float_count   = evt_i.float_count;
      word.int_count     = evt_i.int_count;
      word.text_length   = evt_i.text_length;
      word.is_data_frame = evt_i.is_data_frame;
    end
    m_data_d = word;
    m_last_d = !(split && !phase_q);
    m_user_d = emit_byte ? KindByte : KindStatus;
    phase_d  = phase_q;
    if (load && evt_valid_i) begin
      phase_d = split && !phase_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      phase_q   <= 1'b0;
    end else begin
      if (load) begin
        m_valid_q <= evt_valid_i;
      end
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && evt_valid_i) begin
      m_data_q <= m_data_d;
      m_last_q <= m_last_d;
      m_user_q <= m_user_d;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_last_o  = m_last_q;
  assign m_user_o  = m_user_q;

  a_phase_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> evt_valid_i && evt_i.has_byte && evt_i.has_status)
    else $error("second half pending without a split event at queue head");

endmodule

@@ rtl/core/base64_frame_fletcher_decoder_unit.sv @@
// Top level of the base64 frame decoder with Fletcher-16 check.
// A word whose character completes a payload byte or ends a message is queued at the
// accepting edge and then loaded into the output register once that register is free.
// Throughput: one character per cycle while the event queue is not full, as the front end
// updates byte assembly and checksum state as each character is accepted; a message end
// that also completes a payload byte gives two output words.
// Reset (rst_ni low, asynchronous): frame state and queue are cleared, mask reads 0x20.
module base64_frame_fletcher_decoder_unit import b64fd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  // Configuration: data-frame id mask.
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,

  // Character input.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] char_code
  input  logic                s_axis_tlast,  // last character of the message

  // Result output.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] byte_value, [14:8] byte_offset, [16:15] status, [24:17] msg_id,
  // [56:25] time_stamp, [60:57] float_count, [64:61] int_count,
  // [72:65] text_length, [73] is_data_frame, [79:74] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,  // end_of_run: last word this character causes
  output logic                m_axis_tuser   // [0] kind: 0 payload byte, 1 frame status
);

  // The front end parses every character in the cycle it is accepted and emits at
  // most one event per character; the queue lets the output side stall without
  // stopping input until it fills.
  logic push;
  evt_t push_evt;
  logic full;
  logic head_valid;
  evt_t head_evt;
  logic pop;

  b64fd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_last_i    (s_axis_tlast),
    .full_i      (full),
    .push_o      (push),
    .evt_o       (push_evt)
  );

  b64fd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .evt_i       (push_evt),
    .full_o      (full),
    .evt_valid_o (head_valid),
    .evt_o       (head_evt),
    .pop_i       (pop)
  );

  // The back end turns an event into one or two words, payload byte first.
  b64fd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (head_valid),
    .evt_i       (head_evt),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast),
    .m_user_o    (m_axis_tuser)
  );

endmodule
